// File: design/assert_macros.svh
// Assertion macros shared by the design files.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ryp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryp_pkg
// Types, coefficients and register codes of the RGB to YUYV 4:2:2 packer.
// ----------------------------------------------------------------------------
package ryp_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
	} ycc_t;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] chroma_blue;
		logic [7:0] luma_second;
		logic [7:0] chroma_red;
		logic       row_done;
		logic       frame_done;
	} yuyv_t;

	// Configuration port.
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
	localparam logic [CFG_DATA_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_DATA_W-1:0]  FRAME_HEIGHT_RST = 13'd480;

	// Fixed-point BT.601 coefficients, eight fractional bits.
	localparam int SUM_W = 17;
	localparam logic signed [SUM_W-1:0] K_YR  = 17'sd66;
	localparam logic signed [SUM_W-1:0] K_YG  = 17'sd129;
	localparam logic signed [SUM_W-1:0] K_YB  = 17'sd25;
	localparam logic signed [SUM_W-1:0] K_UR  = -17'sd38;
	localparam logic signed [SUM_W-1:0] K_UG  = -17'sd74;
	localparam logic signed [SUM_W-1:0] K_UB  = 17'sd112;
	localparam logic signed [SUM_W-1:0] K_VR  = 17'sd112;
	localparam logic signed [SUM_W-1:0] K_VG  = -17'sd94;
	localparam logic signed [SUM_W-1:0] K_VB  = -17'sd18;
	localparam logic signed [SUM_W-1:0] K_RND = 17'sd128;

	localparam logic signed [10:0] LUMA_OFS   = 11'sd16;
	localparam logic signed [10:0] CHROMA_OFS = 11'sd128;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	// Floor shift by eight, add the offset and clamp to one byte.
	function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] sum,
			input logic signed [10:0] offset);
		logic signed [10:0] t;
		t = 11'(sum >>> 8) + offset;
		if (t < 11'sd0) begin
			return 8'd0;
		end else if (t > 11'sd255) begin
			return 8'd255;
		end
		return t[7:0];
	endfunction

endpackage

// File: design/ryp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryp_stream_if
// Valid/ready stream carrying one payload word per transaction.
// ----------------------------------------------------------------------------
interface ryp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/ryp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryp_front
// Two-stage color conversion: weighted sums, then floor shift and clamp.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ryp_front (
	input logic         clk,
	input logic         arst_n,
	ryp_stream_if.sink  pixel,
	ryp_stream_if.source ycc
);
	import ryp_pkg::*;

	logic                    adv;
	logic                    v_s1;
	logic                    v_s2;
	logic signed [SUM_W-1:0] y_sum_s1;
	logic signed [SUM_W-1:0] u_sum_s1;
	logic signed [SUM_W-1:0] v_sum_s1;
	ycc_t                    ycc_s2;
	logic signed [SUM_W-1:0] r_ext;
	logic signed [SUM_W-1:0] g_ext;
	logic signed [SUM_W-1:0] b_ext;

	// The whole pipe moves when the last stage is empty or its word leaves.
	assign adv         = !v_s2 || ycc.ready;
	assign pixel.ready = adv;
	assign ycc.valid   = v_s2;
	assign ycc.data    = ycc_s2;

	assign r_ext = signed'(SUM_W'(pixel.data.red));
	assign g_ext = signed'(SUM_W'(pixel.data.green));
	assign b_ext = signed'(SUM_W'(pixel.data.blue));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pixel.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_sum_s1 <= K_YR * r_ext + K_YG * g_ext + K_YB * b_ext + K_RND;
			u_sum_s1 <= K_UR * r_ext + K_UG * g_ext + K_UB * b_ext + K_RND;
			v_sum_s1 <= K_VR * r_ext + K_VG * g_ext + K_VB * b_ext + K_RND;
			ycc_s2.luma <= clamp_byte(y_sum_s1, LUMA_OFS);
			ycc_s2.cb   <= clamp_byte(u_sum_s1, CHROMA_OFS);
			ycc_s2.cr   <= clamp_byte(v_sum_s1, CHROMA_OFS);
		end
	end

	// A stall only happens with a converted pixel waiting, and it stays there.
	`ASSERT_CLK(a_stall_keeps_word, !pixel.ready |=> v_s2, "front stall lost its word")

endmodule

// File: design/ryp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryp_fifo
// Short queue of converted pixels between the converter and the packer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ryp_fifo (
	input logic          clk,
	input logic          arst_n,
	ryp_stream_if.sink   wr,
	ryp_stream_if.source rd
);
	import ryp_pkg::*;

	ycc_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   push;
	logic                   pop;

	assign wr.ready = (count_q != QUEUE_PTR_W'(0) + (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.data  = mem_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, count_q <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH), "queue overfilled")

endmodule

// File: design/ryp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryp_back
// Pairs converted pixels of a row into YUYV words and tracks row and frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ryp_back #(
	parameter int MAX_SIDE = 4096
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [ryp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [ryp_pkg::CFG_DATA_W-1:0]  cfg_data,
	ryp_stream_if.sink                   ycc,
	ryp_stream_if.source                 yuyv
);
	import ryp_pkg::*;

	localparam int IW = $clog2(MAX_SIDE);
	localparam logic [IW-1:0] LAST_MAX = IW'(MAX_SIDE - 1);

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [IW-1:0]         last_col_idx;
	logic [IW-1:0]         last_row_idx;

	logic [7:0]    held_luma_q;
	logic [7:0]    held_cb_q;
	logic [7:0]    held_cr_q;
	logic          half_q;
	logic [IW-1:0] col_q;
	logic [IW-1:0] row_q;

	yuyv_t out_q;
	logic  out_valid_q;

	logic  out_free;
	logic  last_col;
	logic  last_row;
	logic  emits;
	logic  pop;
	logic [8:0] cb_sum;
	logic [8:0] cr_sum;

	// Index of the last column and row; zero means one, large values saturate.
	always_comb begin
		if (width_q == '0) begin
			last_col_idx = '0;
		end else if (32'(width_q) > 32'(MAX_SIDE)) begin
			last_col_idx = LAST_MAX;
		end else begin
			last_col_idx = IW'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			last_row_idx = '0;
		end else if (32'(height_q) > 32'(MAX_SIDE)) begin
			last_row_idx = LAST_MAX;
		end else begin
			last_row_idx = IW'(height_q - 1'b1);
		end
	end

	assign out_free   = !out_valid_q || yuyv.ready;
	assign last_col   = (col_q >= last_col_idx);
	assign last_row   = (row_q >= last_row_idx);
	assign emits      = half_q || last_col;
	assign ycc.ready  = !emits || out_free;
	assign pop        = ycc.valid && ycc.ready;
	assign cb_sum     = {1'b0, held_cb_q} + {1'b0, ycc.data.cb};
	assign cr_sum     = {1'b0, held_cr_q} + {1'b0, ycc.data.cr};
	assign yuyv.valid = out_valid_q;
	assign yuyv.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default:          width_q  <= width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_luma_q <= '0;
			held_cb_q   <= '0;
			held_cr_q   <= '0;
			half_q      <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && emits) begin
				out_valid_q <= 1'b1;
			end else if (yuyv.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (!emits) begin
					held_luma_q <= ycc.data.luma;
					held_cb_q   <= ycc.data.cb;
					held_cr_q   <= ycc.data.cr;
					half_q      <= 1'b1;
					col_q       <= col_q + 1'b1;
				end else begin
					half_q <= 1'b0;
					if (last_col) begin
						col_q <= '0;
						row_q <= last_row ? '0 : row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			if (half_q) begin
				out_q.luma_first  <= held_luma_q;
				out_q.chroma_blue <= cb_sum[8:1];
				out_q.chroma_red  <= cr_sum[8:1];
			end else begin
				out_q.luma_first  <= ycc.data.luma;
				out_q.chroma_blue <= ycc.data.cb;
				out_q.chroma_red  <= ycc.data.cr;
			end
			out_q.luma_second <= ycc.data.luma;
			out_q.row_done    <= last_col;
			out_q.frame_done  <= last_col && last_row;
		end
	end

	// A waiting even pixel always sits past the start of its row.
	`ASSERT_CLK(a_half_not_col0, half_q |-> (col_q != '0), "half pair at column zero")
	// The end of a frame is always also the end of a row.
	`ASSERT_CLK(a_frame_ends_row, (out_valid_q && out_q.frame_done) |-> out_q.row_done, "frame end without row end")

endmodule

// File: design/rgb_to_yuyv422_packer.sv
`timescale 1ns / 1ps
// Path: a pair's second pixel passes stage 1, stage 2, the queue and the output register.
// Throughput: one pixel per cycle unstalled, one word per two pixels (one at an odd row end).
// The rate is set by the two-stage converter, the 4-entry queue and the output register.
// Reset (arst_n low): counters and the held half pair clear, width 640, height 480.
// ----------------------------------------------------------------------------
// rgb_to_yuyv422_packer
// Converts RGB pixels to BT.601 YCbCr and packs pixel pairs into YUYV words.
// ----------------------------------------------------------------------------
module rgb_to_yuyv422_packer #(
	parameter int MAX_SIDE = 4096
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [ryp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [ryp_pkg::CFG_DATA_W-1:0]  cfg_data,
	ryp_stream_if.sink                     pixel,
	ryp_stream_if.source                   yuyv
);
	import ryp_pkg::*;

	ryp_stream_if #(.payload_t(ycc_t)) conv ();
	ryp_stream_if #(.payload_t(ycc_t)) queued ();

	ryp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.ycc    (conv)
	);

	ryp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (conv),
		.rd     (queued)
	);

	ryp_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ycc       (queued),
		.yuyv      (yuyv)
	);

endmodule
